// ===== design/range_memory_type_resolver_macros.svh =====
// assertion macros used by the checks of the top level
`ifndef RANGE_MEMORY_TYPE_RESOLVER_MACROS_SVH
`define RANGE_MEMORY_TYPE_RESOLVER_MACROS_SVH

// overlapping implication, clocked on i_clk, off during reset
`define RMTR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define RMTR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rmtr_pkg.sv =====
package rmtr_pkg;

    // defaults for the top level parameters
    localparam int MAX_RANGES_DEF = 16;
    localparam int ADDR_BITS_DEF  = 52;

    // fixed field widths
    localparam int TYPE_W      = 3;
    localparam int SLOT_W      = 4;
    localparam int ACTIVE_W    = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // uncachable type decides outright
    localparam logic [TYPE_W-1:0] MT_UC = 3'd0;

    // item kinds
    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEFAULT_TYPE  = 2'd0,
        CFG_ACTIVE_RANGES = 2'd1
    } t_cfg_reg;

    // configuration seen by the datapath
    typedef struct packed {
        logic [TYPE_W-1:0]   default_type;
        logic [ACTIVE_W-1:0] active_ranges;
    } t_cfg;

endpackage

// ===== design/rmtr_table.sv =====
module rmtr_table #(
    parameter int MAX_RANGES = rmtr_pkg::MAX_RANGES_DEF,
    parameter int ADDR_BITS  = rmtr_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_kind,
    input  logic [rmtr_pkg::SLOT_W-1:0]       i_slot,
    input  logic [ADDR_BITS-1:0]              i_base,
    input  logic [ADDR_BITS-1:0]              i_limit,
    input  logic [rmtr_pkg::TYPE_W-1:0]       i_type,
    input  logic                              i_fixed,
    input  logic [ADDR_BITS-1:0]              i_addr,
    input  rmtr_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    output logic [MAX_RANGES-1:0]             o_hit,
    output logic [MAX_RANGES-1:0]             o_decisive,
    output logic [MAX_RANGES-1:0][rmtr_pkg::TYPE_W-1:0] o_types
);

    // compare width covers the entry count and the active count field
    localparam int CW = ($clog2(MAX_RANGES) + 1 > rmtr_pkg::ACTIVE_W) ?
                        $clog2(MAX_RANGES) + 1 : rmtr_pkg::ACTIVE_W;

    logic                        r_s1_valid;
    rmtr_pkg::t_kind             r_s1_kind;
    logic [rmtr_pkg::SLOT_W-1:0] r_s1_slot;
    logic [ADDR_BITS-1:0]        r_s1_base;
    logic [ADDR_BITS-1:0]        r_s1_limit;
    logic [rmtr_pkg::TYPE_W-1:0] r_s1_type;
    logic                        r_s1_fixed;
    logic [ADDR_BITS-1:0]        r_s1_addr;

    logic [ADDR_BITS-1:0]        r_base  [MAX_RANGES];
    logic [ADDR_BITS-1:0]        r_limit [MAX_RANGES];
    logic [rmtr_pkg::TYPE_W-1:0] r_type  [MAX_RANGES];
    logic                        r_fixed [MAX_RANGES];

    logic                        r_s2_valid;
    logic [MAX_RANGES-1:0]       r_s2_hit;
    logic [MAX_RANGES-1:0]       r_s2_dec;
    logic [MAX_RANGES-1:0][rmtr_pkg::TYPE_W-1:0] r_s2_types;

    logic [MAX_RANGES-1:0]       n_hit;
    logic [MAX_RANGES-1:0]       n_dec;

    // stage 1: capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
        r_s1_kind  <= rmtr_pkg::t_kind'(i_kind);
        r_s1_slot  <= i_slot;
        r_s1_base  <= i_base;
        r_s1_limit <= i_limit;
        r_s1_type  <= i_type;
        r_s1_fixed <= i_fixed;
        r_s1_addr  <= i_addr;
    end

    // range table write, in item order with lookups of stage 1
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RANGES; i++) begin
            if (r_s1_valid && r_s1_kind == rmtr_pkg::KIND_LOAD &&
                CW'(r_s1_slot) == CW'(i)) begin
                r_base[i]  <= r_s1_base;
                r_limit[i] <= r_s1_limit;
                r_type[i]  <= r_s1_type;
                r_fixed[i] <= r_s1_fixed;
            end
        end
    end

    // per-entry containment and decisive match
    always_comb begin
        for (int i = 0; i < MAX_RANGES; i++) begin
            n_hit[i] = (CW'(i) < CW'(i_cfg.active_ranges)) &&
                       (r_s1_addr >= r_base[i]) && (r_s1_addr < r_limit[i]);
            n_dec[i] = n_hit[i] && (r_fixed[i] || r_type[i] == rmtr_pkg::MT_UC);
        end
    end

    // stage 2: match vectors with a snapshot of the entry types
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_kind == rmtr_pkg::KIND_LOOKUP;
        end
        r_s2_hit <= n_hit;
        r_s2_dec <= n_dec;
        for (int i = 0; i < MAX_RANGES; i++) begin
            r_s2_types[i] <= r_type[i];
        end
    end

    assign o_valid    = r_s2_valid;
    assign o_hit      = r_s2_hit;
    assign o_decisive = r_s2_dec;
    assign o_types    = r_s2_types;

endmodule

// ===== design/rmtr_resolve.sv =====
module rmtr_resolve #(
    parameter int MAX_RANGES = rmtr_pkg::MAX_RANGES_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic [MAX_RANGES-1:0]                       i_hit,
    input  logic [MAX_RANGES-1:0]                       i_decisive,
    input  logic [MAX_RANGES-1:0][rmtr_pkg::TYPE_W-1:0] i_types,
    input  logic [rmtr_pkg::TYPE_W-1:0]                 i_default_type,
    output logic                                        o_done,
    output logic [rmtr_pkg::TYPE_W-1:0]                 o_memory_type
);

    logic                  r_s3_valid;
    logic [MAX_RANGES-1:0] r_s3_keep;
    logic [MAX_RANGES-1:0][rmtr_pkg::TYPE_W-1:0] r_s3_types;

    logic                  r_s4_valid;
    logic                  r_s4_any;
    logic [MAX_RANGES-1:0] r_s4_sel;
    logic [MAX_RANGES-1:0][rmtr_pkg::TYPE_W-1:0] r_s4_types;

    logic                        r_done;
    logic [rmtr_pkg::TYPE_W-1:0] r_memory_type;

    logic [MAX_RANGES-1:0] n_first;
    logic [MAX_RANGES-1:0] n_keep;
    logic [MAX_RANGES-1:0] n_rev;
    logic [MAX_RANGES-1:0] n_rev_low;
    logic [MAX_RANGES-1:0] n_sel;
    logic [rmtr_pkg::TYPE_W-1:0] n_type;

    // matches up to and including the first decisive one; all when none is
    always_comb begin
        n_first = i_decisive & (~i_decisive + MAX_RANGES'(1));
        n_keep  = i_hit & (n_first | (n_first - MAX_RANGES'(1)));
    end

    // stage 3: surviving matches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_valid;
        end
        r_s3_keep  <= n_keep;
        r_s3_types <= i_types;
    end

    // last surviving match as a one-hot select
    always_comb begin
        for (int i = 0; i < MAX_RANGES; i++) begin
            n_rev[i] = r_s3_keep[MAX_RANGES-1-i];
        end
        n_rev_low = n_rev & (~n_rev + MAX_RANGES'(1));
        for (int i = 0; i < MAX_RANGES; i++) begin
            n_sel[i] = n_rev_low[MAX_RANGES-1-i];
        end
    end

    // stage 4: select vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        r_s4_any   <= |r_s3_keep;
        r_s4_sel   <= n_sel;
        r_s4_types <= r_s3_types;
    end

    // and-or mux of the selected type
    always_comb begin
        n_type = '0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            n_type = n_type | (r_s4_types[i] & {rmtr_pkg::TYPE_W{r_s4_sel[i]}});
        end
    end

    // stage 5: result register, one strobe per lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s4_valid;
        end
        r_memory_type <= r_s4_any ? n_type : i_default_type;
    end

    assign o_done        = r_done;
    assign o_memory_type = r_memory_type;

endmodule

// ===== design/range_memory_type_resolver.sv =====
// Range memory type resolver.
// Command channel: a transaction is taken at a rising edge with i_start high
// and o_busy low. o_busy stays low, so one transaction can be taken every
// cycle. i_kind selects a range load (i_entry_* fields) or an address lookup
// (i_query_address).
// A lookup gives one result: o_done is high for one cycle with o_memory_type.
// The strobe comes out of five register stages (capture, range compare, decisive
// cut, last-match select, output mux), and a new transaction enters each cycle.
// A load gives no result; a lookup sees every load taken before it.
// Configuration channel: i_cfg_valid/o_cfg_ready write register i_cfg_index
// (0 default type, 1 active range count); o_cfg_ready is always high.
// Write configuration only while no lookup is in flight.
// Reset clears the configuration registers and the stage valid bits; range
// entries are undefined until loaded.
// The result cannot be stalled by the receiver: it must be taken the cycle
// o_done is high.
`include "range_memory_type_resolver_macros.svh"

module range_memory_type_resolver #(
    parameter int MAX_RANGES = rmtr_pkg::MAX_RANGES_DEF,
    parameter int ADDR_BITS  = rmtr_pkg::ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_kind,
    input  logic [rmtr_pkg::SLOT_W-1:0]         i_entry_slot,
    input  logic [ADDR_BITS-1:0]                i_entry_base,
    input  logic [ADDR_BITS-1:0]                i_entry_limit,
    input  logic [rmtr_pkg::TYPE_W-1:0]         i_entry_type,
    input  logic                                i_entry_fixed,
    input  logic [ADDR_BITS-1:0]                i_query_address,
    output logic                                o_done,
    output logic [rmtr_pkg::TYPE_W-1:0]         o_memory_type,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rmtr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [rmtr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [rmtr_pkg::TYPE_W-1:0]   r_default_type;
    logic [rmtr_pkg::ACTIVE_W-1:0] r_active_ranges;

    rmtr_pkg::t_cfg        w_cfg;
    logic                  w_accept;
    logic                  w_cfg_write;
    logic                  w_valid;
    logic [MAX_RANGES-1:0] w_hit;
    logic [MAX_RANGES-1:0] w_decisive;
    logic [MAX_RANGES-1:0][rmtr_pkg::TYPE_W-1:0] w_types;
    logic                  w_take_lookup;
    logic                  w_take_load;
    logic                  w_cfg_count;

    // handshakes
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_type  <= '0;
            r_active_ranges <= '0;
        end else if (w_cfg_write) begin
            if (i_cfg_index == rmtr_pkg::CFG_DEFAULT_TYPE) begin
                r_default_type <= i_cfg_data[rmtr_pkg::TYPE_W-1:0];
            end
            if (i_cfg_index == rmtr_pkg::CFG_ACTIVE_RANGES) begin
                r_active_ranges <= i_cfg_data[rmtr_pkg::ACTIVE_W-1:0];
            end
        end
    end

    assign w_cfg.default_type  = r_default_type;
    assign w_cfg.active_ranges = r_active_ranges;

    // range table and compare stages
    rmtr_table #(
        .MAX_RANGES (MAX_RANGES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_kind     (i_kind),
        .i_slot     (i_entry_slot),
        .i_base     (i_entry_base),
        .i_limit    (i_entry_limit),
        .i_type     (i_entry_type),
        .i_fixed    (i_entry_fixed),
        .i_addr     (i_query_address),
        .i_cfg      (w_cfg),
        .o_valid    (w_valid),
        .o_hit      (w_hit),
        .o_decisive (w_decisive),
        .o_types    (w_types)
    );

    // priority resolution stages
    rmtr_resolve #(
        .MAX_RANGES (MAX_RANGES)
    ) u_resolve (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid),
        .i_hit          (w_hit),
        .i_decisive     (w_decisive),
        .i_types        (w_types),
        .i_default_type (w_cfg.default_type),
        .o_done         (o_done),
        .o_memory_type  (o_memory_type)
    );

    // transactions watched by the checks
    assign w_take_lookup = w_accept && i_kind == rmtr_pkg::KIND_LOOKUP;
    assign w_take_load   = w_accept && i_kind == rmtr_pkg::KIND_LOAD;
    assign w_cfg_count   = w_cfg_write && i_cfg_index == rmtr_pkg::CFG_ACTIVE_RANGES;

    // checks
    `RMTR_ASSERT_IMP(a_lookup_result, w_take_lookup, ##5 o_done, "lookup without result")
    `RMTR_ASSERT_IMP(a_load_silent, w_take_load, ##5 !o_done, "load gave a result")
    `RMTR_ASSERT_NXT(a_cfg_count, w_cfg_count,
        r_active_ranges == $past(i_cfg_data), "range count not written")

endmodule
